// ===== rtl/mebe_pkg.sv =====
// Package with the shared types, constants and command decode of the MIDI event byte encoder.
`timescale 1ns / 1ps

package mebe_pkg;

  // Item kinds on the input channel.
  localparam logic OP_EVENT   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Status high nibble codes.
  localparam logic [7:0] CMD_NOTE_OFF   = 8'h80;
  localparam logic [7:0] CMD_NOTE_ON    = 8'h90;
  localparam logic [7:0] CMD_POLY_PRESS = 8'hA0;
  localparam logic [7:0] CMD_CTRL_CHG   = 8'hB0;
  localparam logic [7:0] CMD_PROG_CHG   = 8'hC0;
  localparam logic [7:0] CMD_CHAN_PRESS = 8'hD0;
  localparam logic [7:0] CMD_PITCH_BEND = 8'hE0;
  localparam logic [7:0] CMD_META       = 8'hFF;

  localparam logic VLQ_CONT = 1'b1;

  // Fixed byte slots of one job, sent in slot order, skipping disabled ones.
  localparam int SLOTS       = 7;
  localparam int SLOT_VLQ3   = 0;
  localparam int SLOT_VLQ2   = 1;
  localparam int SLOT_VLQ1   = 2;
  localparam int SLOT_VLQ0   = 3;
  localparam int SLOT_STATUS = 4;
  localparam int SLOT_DATA1  = 5;
  localparam int SLOT_DATA2  = 6;

  // Depth of the job queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_TWO,
    CLS_ONE,
    CLS_META,
    CLS_BAD
  } cmd_class_t;

  typedef struct packed {
    logic [SLOTS-1:0][7:0] slot_bytes;
    logic [SLOTS-1:0]      mask;
    logic                  bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic cmd_class_t classify(input logic [7:0] cmd);
    cmd_class_t cls;
    unique case (cmd) inside
      CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRESS, CMD_CTRL_CHG, CMD_PITCH_BEND: cls = CLS_TWO;
      CMD_PROG_CHG, CMD_CHAN_PRESS: cls = CLS_ONE;
      CMD_META: cls = CLS_META;
      default: cls = CLS_BAD;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/mebe_if.sv =====
// Valid/ready channel interfaces for the event input and the byte output.
`timescale 1ns / 1ps

interface mebe_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        new_track;
  logic [27:0] time_delta;
  logic [7:0]  command;
  logic [3:0]  channel;
  logic [7:0]  data_first;
  logic [7:0]  data_second;
  logic [7:0]  meta_length;
  logic [7:0]  payload_byte;

  modport source (
    output valid, op, new_track, time_delta, command, channel,
           data_first, data_second, meta_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, op, new_track, time_delta, command, channel,
           data_first, data_second, meta_length, payload_byte,
    output ready
  );
endinterface

interface mebe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       bad_command;

  modport source (output valid, out_byte, last, bad_command, input ready);
  modport sink (input valid, out_byte, last, bad_command, output ready);
endinterface

// ===== rtl/midi_event_byte_encoder.sv =====
// Top level of the MIDI track event byte encoder.
`timescale 1ns / 1ps

// Encodes track events into the byte stream of a standard MIDI file. An event
// header item yields its delta time as a variable-length quantity (1 to 4
// bytes, 0x80 set on all but the last), then the status byte when it differs
// from the running status or the event is meta, then the data bytes of the
// command (two for 0x80/0x90/0xA0/0xB0/0xE0, one for 0xC0/0xD0, type and
// length for meta 0xFF). A meta payload item yields its one byte unchanged.
// An unrecognized command yields the time and status bytes only, with
// bad_command set on the last one. new_track clears the running status before
// its event. The output delivers one byte per cycle while the receiver keeps
// ready high; an item makes 1 to 7 bytes. Input items are classified on
// acceptance and enter a two-deep job queue, so the input keeps taking items
// while earlier ones are still being sent; an accepted item passes through
// the queue, the current job register and the output register before its
// first byte appears.
module midi_event_byte_encoder (
  input  logic        clk,
  input  logic        rst_n,
  mebe_in_if.sink     in_ch,
  mebe_out_if.source  out_ch
);

  logic                 push;
  logic                 pop;
  mebe_pkg::job_t       push_job;
  mebe_pkg::job_t       head_job;
  mebe_pkg::q_status_t  q_stat;

  // Front end: running status and per-item byte plan.
  mebe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  // Decouples acceptance from byte sequencing.
  mebe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Back end: one byte per cycle into the output register while the output is not stalled.
  mebe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/mebe_front.sv =====
// Front end: accepts items, tracks running status and builds the byte job for each item.
`timescale 1ns / 1ps

module mebe_front (
  input  logic              clk,
  input  logic              rst_n,
  mebe_in_if.sink           in_ch,
  input  mebe_pkg::q_status_t q_stat,
  output logic              push,
  output mebe_pkg::job_t    job
);

  logic [7:0]            rs_r;
  logic [7:0]            rs_nxt;
  logic [7:0]            rs_eff;
  logic [7:0]            status;
  logic                  send_status;
  logic                  accept;
  mebe_pkg::cmd_class_t  cls;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept;

  assign cls         = mebe_pkg::classify(in_ch.command);
  assign status      = in_ch.command | {4'h0, in_ch.channel};
  assign rs_eff      = in_ch.new_track ? 8'h00 : rs_r;
  assign send_status = (status != rs_eff) || (cls == mebe_pkg::CLS_META);

  always_comb begin
    job = '0;
    if (in_ch.op == mebe_pkg::OP_PAYLOAD) begin
      job.slot_bytes[mebe_pkg::SLOT_VLQ0] = in_ch.payload_byte;
      job.mask[mebe_pkg::SLOT_VLQ0]       = 1'b1;
    end else begin
      job.slot_bytes[mebe_pkg::SLOT_VLQ3]   = {mebe_pkg::VLQ_CONT, in_ch.time_delta[27:21]};
      job.slot_bytes[mebe_pkg::SLOT_VLQ2]   = {mebe_pkg::VLQ_CONT, in_ch.time_delta[20:14]};
      job.slot_bytes[mebe_pkg::SLOT_VLQ1]   = {mebe_pkg::VLQ_CONT, in_ch.time_delta[13:7]};
      job.slot_bytes[mebe_pkg::SLOT_VLQ0]   = {1'b0, in_ch.time_delta[6:0]};
      job.slot_bytes[mebe_pkg::SLOT_STATUS] = status;
      job.slot_bytes[mebe_pkg::SLOT_DATA1]  = in_ch.data_first;
      job.slot_bytes[mebe_pkg::SLOT_DATA2]  =
        (cls == mebe_pkg::CLS_META) ? in_ch.meta_length : in_ch.data_second;
      job.mask[mebe_pkg::SLOT_VLQ3]   = |in_ch.time_delta[27:21];
      job.mask[mebe_pkg::SLOT_VLQ2]   = |in_ch.time_delta[27:14];
      job.mask[mebe_pkg::SLOT_VLQ1]   = |in_ch.time_delta[27:7];
      job.mask[mebe_pkg::SLOT_VLQ0]   = 1'b1;
      job.mask[mebe_pkg::SLOT_STATUS] = send_status;
      job.mask[mebe_pkg::SLOT_DATA1]  = (cls != mebe_pkg::CLS_BAD);
      job.mask[mebe_pkg::SLOT_DATA2]  = (cls == mebe_pkg::CLS_TWO) || (cls == mebe_pkg::CLS_META);
      job.bad                         = (cls == mebe_pkg::CLS_BAD);
    end
  end

  always_comb begin
    rs_nxt = rs_r;
    if (accept && (in_ch.op == mebe_pkg::OP_EVENT)) begin
      rs_nxt = send_status ? status : rs_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= 8'h00;
    end else begin
      rs_r <= rs_nxt;
    end
  end

  // A sent status byte becomes the running status.
  a_rs_follows_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.op == mebe_pkg::OP_EVENT) && send_status |=> rs_r == $past(status))
    else $error("running status did not take the sent status byte");

endmodule

// ===== rtl/mebe_queue.sv =====
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module mebe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mebe_pkg::job_t        push_job,
  input  logic                  pop,
  output mebe_pkg::job_t        head_job,
  output mebe_pkg::q_status_t   q_stat
);

  mebe_pkg::job_t                 store_r [mebe_pkg::QDEPTH];
  logic [mebe_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mebe_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mebe_pkg::QCNT_W-1:0]    count_r, count_nxt;

  localparam logic [mebe_pkg::QPTR_W-1:0] PTR_LAST = mebe_pkg::QPTR_W'(mebe_pkg::QDEPTH - 1);
  localparam logic [mebe_pkg::QCNT_W-1:0] CNT_FULL = mebe_pkg::QCNT_W'(mebe_pkg::QDEPTH);

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign head_job     = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

endmodule

// ===== rtl/mebe_back.sv =====
// Back end: walks the enabled byte slots of each job and drives the output register.
`timescale 1ns / 1ps

module mebe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mebe_pkg::job_t      head_job,
  input  mebe_pkg::q_status_t q_stat,
  output logic                pop,
  mebe_out_if.source          out_ch
);

  logic                          cur_valid_r, cur_valid_nxt;
  mebe_pkg::job_t                cur_r, cur_nxt;
  logic [mebe_pkg::SLOTS-1:0]    sel;
  logic [mebe_pkg::SLOTS-1:0]    rem;
  logic [7:0]                    sel_byte;
  logic                          sel_last;
  logic                          out_load;
  logic                          cur_done;

  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          out_last_r;
  logic                          out_bad_r;

  // Lowest enabled slot goes out next.
  assign sel      = cur_r.mask & (~cur_r.mask + 1'b1);
  assign rem      = cur_r.mask & ~sel;
  assign sel_last = (rem == '0);

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < mebe_pkg::SLOTS; i++) begin
      sel_byte = sel_byte | (cur_r.slot_bytes[i] & {8{sel[i]}});
    end
  end

  assign out_load = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign cur_done = out_load && sel_last;
  assign pop      = !q_stat.empty && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = head_job;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (out_load) begin
      cur_nxt.mask = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (out_load) begin
      out_byte_r <= sel_byte;
      out_last_r <= sel_last;
      out_bad_r  <= sel_last && cur_r.bad;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.bad_command = out_bad_r;

  // Every job holds at least its low time byte or payload byte.
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_r.mask != '0)
    else $error("active job has no bytes left");

  a_bad_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r)
    else $error("bad command flag on a byte that is not the last");

endmodule
